FILE: rtl/core/dmmbs_pkg.sv
// Package for the two-strand IUPAC DNA motif matcher.
// Widths, register indexes, base codes and small helper functions.
// No dependencies.
package dmmbs_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int CODES_HELD    = 16;
    localparam int POSITION_BITS = 32;

    localparam int WIN_DEPTH = (MAX_PATTERN < CODES_HELD) ? MAX_PATTERN : CODES_HELD;
    localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    localparam int BASE_W     = 8;
    localparam int CODE_W     = 4;
    localparam int LEN_W      = 5;
    localparam int CODES_W    = 64;
    localparam int OUT_POS_W  = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CODES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

    localparam logic [CODES_W-1:0] PATTERN_CODES_RST  = 64'h0000_0000_0001_1111;
    localparam logic [LEN_W-1:0]   PATTERN_LENGTH_RST = 5'd5;
    localparam logic [LEN_W-1:0]   LEN_MIN            = 5'd2;
    localparam logic [LEN_W-1:0]   LEN_MAX            = LEN_W'(WIN_DEPTH);

    localparam logic [CODE_W-1:0] CODE_NONE = 4'b0000;
    localparam logic [CODE_W-1:0] CODE_A    = 4'b0001;
    localparam logic [CODE_W-1:0] CODE_C    = 4'b0010;
    localparam logic [CODE_W-1:0] CODE_G    = 4'b0100;
    localparam logic [CODE_W-1:0] CODE_T    = 4'b1000;

    localparam logic [BASE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BASE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BASE_W-1:0] ASCII_CASE    = 8'h20;
    localparam logic [BASE_W-1:0] ASCII_A       = 8'h61;
    localparam logic [BASE_W-1:0] ASCII_C       = 8'h63;
    localparam logic [BASE_W-1:0] ASCII_G       = 8'h67;
    localparam logic [BASE_W-1:0] ASCII_T       = 8'h74;

    typedef logic [CODE_W-1:0]        t_code;
    typedef logic [POSITION_BITS-1:0] t_pos;

    typedef struct packed {
        logic fwd;
        logic rev;
        t_pos start;
        t_pos stop;
    } t_entry;

    // a<->t, c<->g
    function automatic t_code complement(input t_code m);
        complement = {m[0], m[1], m[2], m[3]};
    endfunction

    function automatic t_code code_of(input logic [BASE_W-1:0] c);
        logic [BASE_W-1:0] lc;
        lc = ((c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) ? (c + ASCII_CASE) : c;
        case (lc)
            ASCII_A: code_of = CODE_A;
            ASCII_C: code_of = CODE_C;
            ASCII_G: code_of = CODE_G;
            ASCII_T: code_of = CODE_T;
            default: code_of = CODE_NONE;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        if (len < LEN_MIN) begin
            eff_length = LEN_MIN;
        end else if (len > LEN_MAX) begin
            eff_length = LEN_MAX;
        end else begin
            eff_length = len;
        end
    endfunction

endpackage

FILE: rtl/core/dmmbs_if.sv
// Valid/ready channel interfaces for the motif matcher: base requests in,
// match requests out. Depends on dmmbs_pkg.
interface dmmbs_in_if import dmmbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic              new_sequence;

    modport source (output valid, base, new_sequence, input ready);
    modport sink   (input valid, base, new_sequence, output ready);
endinterface

interface dmmbs_out_if import dmmbs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_POS_W-1:0] match_start;
    logic [OUT_POS_W-1:0] match_end;
    logic                 strand;
    logic                 last;

    modport source (output valid, match_start, match_end, strand, last, input ready);
    modport sink   (input valid, match_start, match_end, strand, last, output ready);
endinterface

FILE: rtl/core/dna_motif_match_both_strands.sv
// Top level of the two-strand IUPAC DNA motif matcher.
// Depends on dmmbs_pkg and the channel interfaces in dmmbs_if.sv.
//
// One base request is accepted per clock unless the input stalls. A base is
// registered on entry, then the sliding window is updated and compared against
// the pattern and its reverse complement in one parallel pass; matches land in
// a two-entry result queue that drives the output port. The sustained rate is
// one base per cycle while the queue has room; a window that matches both
// strands yields two result requests (forward first) through the single output
// port, which is what bounds throughput on such stretches. The input stalls only
// when the result queue holds two unfinished entries. The user is to write the
// pattern registers through the config port while idle; it is not enforced.
module dna_motif_match_both_strands import dmmbs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dmmbs_in_if.sink              i_in,
    dmmbs_out_if.source           o_out
);

    logic [CODES_W-1:0] r_codes;
    logic [LEN_W-1:0]   r_len;

    logic              r_in_valid;
    logic [BASE_W-1:0] r_in_base;
    logic              r_in_new;

    t_code             r_window [WIN_DEPTH];
    t_pos              r_pos;
    logic [FILL_W-1:0] r_fill;

    t_entry     r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       r_sub;

    t_code             n_window [WIN_DEPTH];
    t_pos              n_pos;
    logic [FILL_W-1:0] n_fill;
    t_entry            n_entry;
    logic              n_push;

    logic             adv;
    logic             pop;
    logic [LEN_W-1:0] len;
    t_entry           head;

    assign len = eff_length(r_len);
    assign adv = r_in_valid && (r_cnt != 2'd2);

    assign i_in.ready = !r_in_valid || adv;

    // window update and parallel compare
    always_comb begin
        t_pos              here;
        logic [FILL_W-1:0] fill_base;
        logic              fwd;
        logic              rev;
        logic              palin;
        logic [LEN_W-1:0]  rel;
        logic [WIN_IDX_W-1:0] idx;
        t_code             b;
        t_code             f;
        t_code             r;

        for (int k = 0; k < WIN_DEPTH; k++) begin
            if (k == 0) begin
                n_window[k] = code_of(r_in_base);
            end else begin
                n_window[k] = r_in_new ? CODE_NONE : r_window[k-1];
            end
        end

        here      = r_in_new ? '0 : r_pos;
        fill_base = r_in_new ? '0 : r_fill;
        n_pos     = here + t_pos'(1);
        n_fill    = (fill_base < FILL_W'(WIN_DEPTH)) ? (fill_base + FILL_W'(1)) : fill_base;

        fwd   = 1'b1;
        rev   = 1'b1;
        palin = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            rel = len - LEN_W'(1) - LEN_W'(i);
            idx = rel[WIN_IDX_W-1:0];
            b   = n_window[idx];
            f   = r_codes[CODE_W*i +: CODE_W];
            r   = complement(r_codes[CODE_W*idx +: CODE_W]);
            if (LEN_W'(i) < len) begin
                if ((b & f) == CODE_NONE) fwd = 1'b0;
                if ((b & r) == CODE_NONE) rev = 1'b0;
                if (f != r) palin = 1'b0;
            end
        end
        if (palin) rev = 1'b0;

        n_entry.fwd   = fwd;
        n_entry.rev   = rev;
        n_entry.start = here - t_pos'(len - LEN_W'(1));
        n_entry.stop  = here - t_pos'(len - LEN_W'(1)) + t_pos'(len);

        n_push = adv && (n_fill >= FILL_W'(len)) && (fwd || rev);
    end

    assign head = r_q[r_rd];

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.match_start = OUT_POS_W'(head.start);
    assign o_out.match_end   = OUT_POS_W'(head.stop);
    assign o_out.strand      = r_sub || !head.fwd;
    assign o_out.last        = r_sub || !(head.fwd && head.rev);

    assign pop = o_out.valid && o_out.ready && o_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes    <= PATTERN_CODES_RST;
            r_len      <= PATTERN_LENGTH_RST;
            r_in_valid <= 1'b0;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_window[k] <= CODE_NONE;
            end
            r_pos  <= '0;
            r_fill <= '0;
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_cnt  <= 2'd0;
            r_sub  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PATTERN_CODES:  r_codes <= i_cfg_data[CODES_W-1:0];
                    REG_PATTERN_LENGTH: r_len   <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_window <= n_window;
                r_pos    <= n_pos;
                r_fill   <= n_fill;
            end
            if (n_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(n_push) - 2'(pop);
            if (o_out.valid && o_out.ready) begin
                r_sub <= !o_out.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_base <= i_in.base;
            r_in_new  <= i_in.new_sequence;
        end
        if (n_push) begin
            r_q[r_wr] <= n_entry;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_second_is_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> (o_out.valid && o_out.strand && o_out.last))
        else $error("reverse result did not follow forward result");

    a_first_is_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> !o_out.strand)
        else $error("non-final result is not forward strand");

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (head.stop - head.start) == t_pos'(len))
        else $error("match span differs from pattern length");

    a_new_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_new) |=> (r_pos == t_pos'(1)))
        else $error("position not restarted on new sequence");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for dna_motif_match_both_strands: streams base requests,
// predicts forward/reverse motif matches and checks every match request in order.
// Depends on dmmbs_pkg, dmmbs_if.sv and the matcher RTL.
`timescale 1ns / 100ps

module tb_top;
    import dmmbs_pkg::*;

    localparam int IDLE_MAX    = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;
    localparam int DRAIN_LIMIT = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 108;
    localparam int N_ROWS      = 29;

    typedef enum logic [2:0] {ROW_PREDICT, ROW_NONE, ROW_FWD, ROW_REV, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [BASE_W-1:0]     base;
        logic                  nseq;
        logic [OUT_POS_W-1:0]  start;
        logic [OUT_POS_W-1:0]  stop;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_row;

    typedef struct packed {
        logic [OUT_POS_W-1:0] start;
        logic [OUT_POS_W-1:0] stop;
        logic                 strand;
        logic                 last;
    } t_match;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    dmmbs_in_if  in_if ();
    dmmbs_out_if out_if ();

    dna_motif_match_both_strands dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    // predictor state
    t_code                 win [WIN_DEPTH];
    t_pos                  next_pos;
    int                    fill;
    logic [CODES_W-1:0]    pat_codes;
    logic [LEN_W-1:0]      pat_len;

    t_match pending_matches [$];
    t_match step_matches [$];
    t_row   dir_rows [N_ROWS];

    int  errors;
    int  cycle_count;
    int  hold_pending;
    bit  src_idle;
    bit  sink_idle;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int eff_len(input logic [LEN_W-1:0] l);
        if (l < LEN_MIN) return int'(LEN_MIN);
        if (l > LEN_MAX) return int'(LEN_MAX);
        return int'(l);
    endfunction

    // a<->t, c<->g is a bit reversal of the one-hot mask
    function automatic t_code pair_mask(input t_code m);
        t_code x;
        for (int k = 0; k < CODE_W; k++) x[k] = m[CODE_W-1-k];
        return x;
    endfunction

    function automatic void predict_matches(input logic [BASE_W-1:0] raw, input logic nseq);
        logic [BASE_W-1:0] lc;
        t_code             code, b, f, r;
        t_pos              here, start;
        int                len;
        logic              fwd, rev, palin;
        step_matches = {};
        lc = (raw >= ASCII_UPPER_A && raw <= ASCII_UPPER_Z) ? raw + ASCII_CASE : raw;
        case (lc)
            ASCII_A: code = CODE_A;
            ASCII_C: code = CODE_C;
            ASCII_G: code = CODE_G;
            ASCII_T: code = CODE_T;
            default: code = CODE_NONE;
        endcase
        if (nseq) begin
            foreach (win[i]) win[i] = CODE_NONE;
            next_pos = '0;
            fill = 0;
        end
        for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = code;
        here = next_pos;
        next_pos = next_pos + 1'b1;
        if (fill < WIN_DEPTH) fill++;
        len = eff_len(pat_len);
        if (fill < len) return;
        fwd = 1'b1;
        rev = 1'b1;
        palin = 1'b1;
        for (int i = 0; i < len; i++) begin
            b = win[len-1-i];
            f = pat_codes[CODE_W*i +: CODE_W];
            r = pair_mask(pat_codes[CODE_W*(len-1-i) +: CODE_W]);
            if ((b & f) == CODE_NONE) fwd = 1'b0;
            if ((b & r) == CODE_NONE) rev = 1'b0;
            if (f != r) palin = 1'b0;
        end
        if (palin) rev = 1'b0;
        start = here - t_pos'(len - 1);
        if (fwd) step_matches.push_back('{OUT_POS_W'(start), OUT_POS_W'(start + t_pos'(len)),
                                         1'b0, 1'b0});
        if (rev) step_matches.push_back('{OUT_POS_W'(start), OUT_POS_W'(start + t_pos'(len)),
                                         1'b1, 1'b0});
        if (step_matches.size() > 0) step_matches[step_matches.size()-1].last = 1'b1;
    endfunction

    function automatic t_row base_row(input t_row_kind kind, input logic [BASE_W-1:0] base,
                                      input logic nseq, input int start, input int stop);
        return '{kind, base, nseq, OUT_POS_W'(start), OUT_POS_W'(stop), '0, '0};
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        return '{ROW_CFG, '0, 1'b0, '0, '0, idx, data};
    endfunction

    function automatic logic [BASE_W-1:0] letter_for(input t_code m);
        int                k;
        logic [BASE_W-1:0] ch;
        if (m == CODE_NONE) m = '1;
        do k = $urandom_range(0, CODE_W - 1); while (!m[k]);
        case (k)
            0:       ch = ASCII_A;
            1:       ch = ASCII_C;
            2:       ch = ASCII_G;
            default: ch = ASCII_T;
        endcase
        if ($urandom_range(0, 1)) ch = ch - ASCII_CASE;
        return ch;
    endfunction

    function automatic t_code pick_mask();
        int r, a;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, CODE_W - 1);
        if (r < 55) return t_code'(1 << a);
        if (r < 85) return t_code'((1 << a) | (1 << ((a + 1 + $urandom_range(0, 2)) % CODE_W)));
        return t_code'($urandom_range(0, 15));
    endfunction

    task automatic send_base(input logic [BASE_W-1:0] base, input logic nseq,
                             input t_row_kind kind, input logic [OUT_POS_W-1:0] start,
                             input logic [OUT_POS_W-1:0] stop);
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.base = base;
        in_if.new_sequence = nseq;
        in_if.valid = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_matches(base, nseq);
        case (kind)
            ROW_PREDICT: foreach (step_matches[i]) pending_matches.push_back(step_matches[i]);
            ROW_FWD:     pending_matches.push_back('{start, stop, 1'b0, 1'b1});
            ROW_REV:     pending_matches.push_back('{start, stop, 1'b1, 1'b1});
            default: ;
        endcase
    endtask

    // stop offering, wait out every pending match plus the pipeline
    task automatic settle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == REG_PATTERN_CODES) pat_codes = data;
        else pat_len = data[LEN_W-1:0];
    endtask

    task automatic random_phase(input int n_items, input bit hold);
        logic [CODES_W-1:0]    codes;
        logic [CFG_DATA_W-1:0] lenword;
        logic [LEN_W-1:0]      lraw;
        t_code                 m;
        int                    r, len, sent;
        bit                    rc;
        settle();
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 5))
                0:       lraw = 5'd0;
                1:       lraw = 5'd1;
                2:       lraw = 5'd2;
                3:       lraw = 5'd16;
                4:       lraw = 5'd17;
                default: lraw = 5'd31;
            endcase
        end else if (r < 35) begin
            lraw = LEN_W'($urandom_range(7, 16));
        end else begin
            lraw = LEN_W'($urandom_range(2, 6));
        end
        len = eff_len(lraw);
        codes = {$urandom, $urandom};
        for (int i = 0; i < CODES_W / CODE_W; i++) codes[CODE_W*i +: CODE_W] = pick_mask();
        if ($urandom_range(0, 5) == 0) begin
            // self-complementary pattern: reverse strand must stay silent
            for (int i = 0; i < len / 2; i++)
                codes[CODE_W*(len-1-i) +: CODE_W] = pair_mask(codes[CODE_W*i +: CODE_W]);
            if (len % 2) begin
                m = codes[CODE_W*(len/2) +: CODE_W];
                codes[CODE_W*(len/2) +: CODE_W] = m | pair_mask(m);
            end
        end
        lenword = {$urandom, $urandom};
        lenword[LEN_W-1:0] = lraw;
        r = $urandom_range(0, 9);
        if (r != 0) write_reg(REG_PATTERN_CODES, codes);
        if (r != 1) write_reg(REG_PATTERN_LENGTH, lenword);
        src_idle = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
        if (hold) begin
            src_idle = 1'b0;
            hold_pending = HOLD_CYCLES;
        end
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 55) begin
                len = eff_len(pat_len);
                rc = $urandom_range(0, 1);
                for (int i = 0; i < len; i++) begin
                    m = rc ? pair_mask(pat_codes[CODE_W*(len-1-i) +: CODE_W])
                           : pat_codes[CODE_W*i +: CODE_W];
                    send_base(letter_for(m), (i == 0) && ($urandom_range(0, 9) == 0),
                              ROW_PREDICT, '0, '0);
                end
                sent += len;
            end else begin
                send_base(($urandom_range(0, 9) < 7) ? letter_for('1)
                                                     : BASE_W'($urandom_range(0, 255)),
                          $urandom_range(0, 49) == 0, ROW_PREDICT, '0, '0);
                sent++;
            end
        end
    endtask

    // match sink: random stalls, one long hold-off on request
    initial begin : match_sink
        t_match want;
        int     stall;
        forever begin
            @(negedge i_clk);
            if (hold_pending > 0) begin
                out_if.ready = 1'b0;
                repeat (hold_pending) @(negedge i_clk);
                hold_pending = 0;
            end
            stall = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall > 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            if (pending_matches.size() == 0) begin
                $error("unexpected match: match_start %0d strand %0b",
                       out_if.match_start, out_if.strand);
                errors++;
            end else begin
                want = pending_matches.pop_front();
                if (out_if.match_start !== want.start) begin
                    $error("match_start: expected %0d, got %0d", want.start, out_if.match_start);
                    errors++;
                end
                if (out_if.match_end !== want.stop) begin
                    $error("match_end: expected %0d, got %0d", want.stop, out_if.match_end);
                    errors++;
                end
                if (out_if.strand !== want.strand) begin
                    $error("strand: expected %0b, got %0b", want.strand, out_if.strand);
                    errors++;
                end
                if (out_if.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, out_if.last);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int waited;
        errors = 0;
        cycle_count = 0;
        hold_pending = 0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.base = '0;
        in_if.new_sequence = 1'b0;
        out_if.ready = 1'b0;
        foreach (win[i]) win[i] = CODE_NONE;
        next_pos = '0;
        fill = 0;
        pat_codes = PATTERN_CODES_RST;
        pat_len = PATTERN_LENGTH_RST;

        dir_rows = '{
            // reset pattern: five a
            base_row(ROW_NONE,    8'h41, 1'b1, 0, 0),
            base_row(ROW_NONE,    8'h61, 1'b0, 0, 0),
            base_row(ROW_NONE,    8'h41, 1'b0, 0, 0),
            base_row(ROW_NONE,    8'h61, 1'b0, 0, 0),
            base_row(ROW_FWD,     8'h61, 1'b0, 0, 5),
            base_row(ROW_FWD,     8'h41, 1'b0, 1, 6),
            base_row(ROW_PREDICT, 8'h5A, 1'b0, 0, 0),
            base_row(ROW_PREDICT, 8'h40, 1'b0, 0, 0),
            base_row(ROW_PREDICT, 8'hFF, 1'b0, 0, 0),
            base_row(ROW_NONE,    8'h54, 1'b1, 0, 0),
            base_row(ROW_NONE,    8'h74, 1'b0, 0, 0),
            base_row(ROW_NONE,    8'h54, 1'b0, 0, 0),
            base_row(ROW_NONE,    8'h74, 1'b0, 0, 0),
            base_row(ROW_REV,     8'h74, 1'b0, 0, 5),
            base_row(ROW_NONE,    8'h00, 1'b1, 0, 0),
            // acgt is its own reverse complement
            cfg_row(REG_PATTERN_CODES,  64'h8421),
            cfg_row(REG_PATTERN_LENGTH, 64'd4),
            base_row(ROW_NONE,    8'h61, 1'b1, 0, 0),
            base_row(ROW_NONE,    8'h43, 1'b0, 0, 0),
            base_row(ROW_NONE,    8'h67, 1'b0, 0, 0),
            base_row(ROW_FWD,     8'h54, 1'b0, 0, 4),
            // all-N pattern, length below minimum, mid-sequence change
            cfg_row(REG_PATTERN_CODES,  '1),
            cfg_row(REG_PATTERN_LENGTH, 64'd0),
            base_row(ROW_FWD,     8'h67, 1'b0, 3, 5),
            // zero masks match nothing
            cfg_row(REG_PATTERN_CODES,  '0),
            cfg_row(REG_PATTERN_LENGTH, 64'd1),
            base_row(ROW_NONE,    8'h63, 1'b0, 0, 0),
            base_row(ROW_PREDICT, 8'h41, 1'b1, 0, 0),
            base_row(ROW_PREDICT, 8'h80, 1'b0, 0, 0)
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_base(dir_rows[k].base, dir_rows[k].nseq, dir_rows[k].kind,
                          dir_rows[k].start, dir_rows[k].stop);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) random_phase(PHASE_ITEMS, ph == 3);

        @(negedge i_clk);
        in_if.valid = 1'b0;
        waited = 0;
        while (pending_matches.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_matches.size() != 0) begin
            $error("%0d matches never arrived", pending_matches.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
